FILE: rtl/window_sum_3x3_extremes_top_defines.svh
// assertion macros shared by the checker
`ifndef WINDOW_SUM_3X3_EXTREMES_TOP_DEFINES_SVH
`define WINDOW_SUM_3X3_EXTREMES_TOP_DEFINES_SVH

// same-cycle implication
`define WSX_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window sum check failed");

// next-cycle implication
`define WSX_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window sum check failed");

`endif

FILE: rtl/wsx_pkg.sv
package wsx_pkg;

  localparam int CFG_INDEX_BITS = 2;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_ROW_COUNT    = 2'd0;
  localparam cfg_index_t REG_COLUMN_COUNT = 2'd1;

  localparam int MIN_DIM = 3;

  typedef struct packed {
    logic valid;
    logic full;
    logic last;
  } stage_ctl_t;

endpackage

FILE: rtl/wsx_front.sv
module wsx_front
  import wsx_pkg::*;
#(
  parameter int MAX_DIM      = 32,
  parameter int ELEMENT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic                            advance,
  input  logic                            accept,
  input  logic [ELEMENT_BITS-1:0]         element_value,
  input  logic [$clog2(MAX_DIM)-1:0]      row_last,
  input  logic [$clog2(MAX_DIM)-1:0]      col_last,
  output stage_ctl_t                      sum_ctl,
  output logic [ELEMENT_BITS+3:0]         sum,
  output logic [$clog2(MAX_DIM)-1:0]      sum_top,
  output logic [$clog2(MAX_DIM)-1:0]      sum_left
);

  localparam int POS_BITS = $clog2(MAX_DIM);
  localparam int SUM_BITS = ELEMENT_BITS + 4;

  logic [POS_BITS-1:0]       row_pos, row_pos_next;
  logic [POS_BITS-1:0]       col_pos, col_pos_next;
  logic                      col_end, row_end;

  logic [2*ELEMENT_BITS-1:0] line_mem [MAX_DIM];
  logic [2*ELEMENT_BITS-1:0] line_rd;

  logic [ELEMENT_BITS-1:0]   win [9];
  logic [SUM_BITS-1:0]       win_sum;

  stage_ctl_t                win_ctl;
  logic [POS_BITS-1:0]       win_top, win_left;

  always_comb begin
    col_end      = (col_pos == col_last);
    row_end      = (row_pos == row_last);
    row_pos_next = row_pos;
    col_pos_next = col_pos;
    if (restart) begin
      row_pos_next = '0;
      col_pos_next = '0;
    end else if (accept) begin
      if (col_end) begin
        col_pos_next = '0;
        row_pos_next = row_end ? '0 : row_pos + POS_BITS'(1);
      end else begin
        col_pos_next = col_pos + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // two line buffers packed in one word: low half one row up, high half two rows up
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_pos] <= {line_rd[ELEMENT_BITS-1:0], element_value};
    end
    line_rd <= line_mem[col_pos_next];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= line_rd[2*ELEMENT_BITS-1:ELEMENT_BITS];
      win[5] <= line_rd[ELEMENT_BITS-1:0];
      win[8] <= element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      win_ctl <= '0;
    end else if (advance) begin
      win_ctl.valid <= accept;
      win_ctl.full  <= (row_pos >= POS_BITS'(2)) && (col_pos >= POS_BITS'(2));
      win_ctl.last  <= col_end && row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win_top  <= row_pos - POS_BITS'(2);
      win_left <= col_pos - POS_BITS'(2);
    end
  end

  always_comb begin
    win_sum = '0;
    for (int k = 0; k < 9; k++) begin
      win_sum = win_sum + SUM_BITS'(win[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sum_ctl <= '0;
    end else if (advance) begin
      sum_ctl <= win_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum      <= win_sum;
      sum_top  <= win_top;
      sum_left <= win_left;
    end
  end

endmodule

FILE: rtl/wsx_track.sv
module wsx_track
  import wsx_pkg::*;
#(
  parameter int MAX_DIM      = 32,
  parameter int ELEMENT_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic                       advance,
  input  stage_ctl_t                 sum_ctl,
  input  logic [ELEMENT_BITS+3:0]    sum,
  input  logic [$clog2(MAX_DIM)-1:0] sum_top,
  input  logic [$clog2(MAX_DIM)-1:0] sum_left,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [ELEMENT_BITS+3:0]    largest_sum,
  output logic [$clog2(MAX_DIM)-1:0] largest_top_row,
  output logic [$clog2(MAX_DIM)-1:0] largest_left_col,
  output logic [ELEMENT_BITS+3:0]    smallest_sum,
  output logic [$clog2(MAX_DIM)-1:0] smallest_top_row,
  output logic [$clog2(MAX_DIM)-1:0] smallest_left_col
);

  localparam int POS_BITS = $clog2(MAX_DIM);
  localparam int SUM_BITS = ELEMENT_BITS + 4;

  logic                seeded, seeded_next;
  logic [SUM_BITS-1:0] hi_sum, hi_sum_next, lo_sum, lo_sum_next;
  logic [POS_BITS-1:0] hi_top, hi_top_next, hi_left, hi_left_next;
  logic [POS_BITS-1:0] lo_top, lo_top_next, lo_left, lo_left_next;
  logic                done;

  assign done = sum_ctl.valid && sum_ctl.last;

  always_comb begin
    seeded_next  = seeded;
    hi_sum_next  = hi_sum;
    hi_top_next  = hi_top;
    hi_left_next = hi_left;
    lo_sum_next  = lo_sum;
    lo_top_next  = lo_top;
    lo_left_next = lo_left;
    if (sum_ctl.valid && sum_ctl.full) begin
      if (!seeded) begin
        seeded_next  = 1'b1;
        hi_sum_next  = sum;
        hi_top_next  = sum_top;
        hi_left_next = sum_left;
        lo_sum_next  = sum;
        lo_top_next  = sum_top;
        lo_left_next = sum_left;
      end else begin
        // ties go to the smaller left column
        if (sum > hi_sum || (sum == hi_sum && sum_left < hi_left)) begin
          hi_sum_next  = sum;
          hi_top_next  = sum_top;
          hi_left_next = sum_left;
        end
        if (sum < lo_sum || (sum == lo_sum && sum_left < lo_left)) begin
          lo_sum_next  = sum;
          lo_top_next  = sum_top;
          lo_left_next = sum_left;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      seeded <= 1'b0;
    end else if (advance) begin
      seeded <= done ? 1'b0 : seeded_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hi_sum  <= hi_sum_next;
      hi_top  <= hi_top_next;
      hi_left <= hi_left_next;
      lo_sum  <= lo_sum_next;
      lo_top  <= lo_top_next;
      lo_left <= lo_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      largest_sum       <= hi_sum_next;
      largest_top_row   <= hi_top_next;
      largest_left_col  <= hi_left_next;
      smallest_sum      <= lo_sum_next;
      smallest_top_row  <= lo_top_next;
      smallest_left_col <= lo_left_next;
    end
  end

endmodule

FILE: rtl/window_sum_3x3_extremes_top.sv
// result_valid rises after the last element of a matrix passes the win_ctl and sum_ctl registers
// throughput: one element per cycle unless a stall drops item_ready, set by the single line buffer read per cycle
// output register frees the input side while a result waits, stalling only if a
// second result is due before the first is taken
// reset: positions, the seeded flag and handshakes clear, dimensions return to 3x3;
// line buffer contents are not cleared, no clearing pass
module window_sum_3x3_extremes_top
  import wsx_pkg::*;
#(
  parameter int MAX_DIM      = 32,
  parameter int ELEMENT_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  cfg_index_t                 cfg_index,
  input  logic [$clog2(MAX_DIM):0]   cfg_data,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [ELEMENT_BITS-1:0]    element_value,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [ELEMENT_BITS+3:0]    largest_sum,
  output logic [$clog2(MAX_DIM)-1:0] largest_top_row,
  output logic [$clog2(MAX_DIM)-1:0] largest_left_col,
  output logic [ELEMENT_BITS+3:0]    smallest_sum,
  output logic [$clog2(MAX_DIM)-1:0] smallest_top_row,
  output logic [$clog2(MAX_DIM)-1:0] smallest_left_col
);

  localparam int POS_BITS = $clog2(MAX_DIM);
  localparam int DIM_BITS = POS_BITS + 1;
  localparam int SUM_BITS = ELEMENT_BITS + 4;

  logic [POS_BITS-1:0] row_last, col_last, dim_last;
  logic                row_write, col_write, restart;
  logic                stall, advance, accept;

  stage_ctl_t          sum_ctl;
  logic [SUM_BITS-1:0] sum;
  logic [POS_BITS-1:0] sum_top, sum_left;

  assign cfg_ready = 1'b1;

  // dimension held as last index, clamped to the supported range
  always_comb begin
    if (cfg_data < DIM_BITS'(MIN_DIM)) begin
      dim_last = POS_BITS'(MIN_DIM - 1);
    end else if (cfg_data > DIM_BITS'(MAX_DIM)) begin
      dim_last = POS_BITS'(MAX_DIM - 1);
    end else begin
      dim_last = POS_BITS'(cfg_data - DIM_BITS'(1));
    end
  end

  always_comb begin
    row_write = 1'b0;
    col_write = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_write = 1'b1;
        REG_COLUMN_COUNT: col_write = 1'b1;
        default: ;
      endcase
    end
  end

  assign restart = row_write || col_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_last <= POS_BITS'(MIN_DIM - 1);
      col_last <= POS_BITS'(MIN_DIM - 1);
    end else begin
      if (row_write) row_last <= dim_last;
      if (col_write) col_last <= dim_last;
    end
  end

  assign stall      = sum_ctl.valid && sum_ctl.last && result_valid && !result_ready;
  assign advance    = !stall;
  assign item_ready = !stall;
  assign accept     = item_valid && item_ready;

  wsx_front #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .advance       (advance),
    .accept        (accept),
    .element_value (element_value),
    .row_last      (row_last),
    .col_last      (col_last),
    .sum_ctl       (sum_ctl),
    .sum           (sum),
    .sum_top       (sum_top),
    .sum_left      (sum_left)
  );

  wsx_track #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_track (
    .clk               (clk),
    .rst               (rst),
    .restart           (restart),
    .advance           (advance),
    .sum_ctl           (sum_ctl),
    .sum               (sum),
    .sum_top           (sum_top),
    .sum_left          (sum_left),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .largest_sum       (largest_sum),
    .largest_top_row   (largest_top_row),
    .largest_left_col  (largest_left_col),
    .smallest_sum      (smallest_sum),
    .smallest_top_row  (smallest_top_row),
    .smallest_left_col (smallest_left_col)
  );

endmodule

FILE: rtl/wsx_checker.sv
`include "window_sum_3x3_extremes_top_defines.svh"

module wsx_checker #(
  parameter int SUM_BITS = 12
) (
  input logic                clk,
  input logic                rst,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic [SUM_BITS-1:0] largest_sum,
  input logic [SUM_BITS-1:0] smallest_sum
);

  `WSX_ASSERT_NXT(result_held, result_valid && !result_ready,
                  result_valid && $stable(largest_sum) && $stable(smallest_sum))
  `WSX_ASSERT_IMP(result_ordered, result_valid, largest_sum >= smallest_sum)
  `WSX_ASSERT_IMP(quiet_after_reset, $past(rst), !result_valid)
  `WSX_ASSERT_IMP(ready_low_on_stall, !item_ready, result_valid && !result_ready)

endmodule

bind window_sum_3x3_extremes_top wsx_checker #(
  .SUM_BITS (ELEMENT_BITS + 4)
) u_wsx_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .largest_sum  (largest_sum),
  .smallest_sum (smallest_sum)
);

FILE: dv/window_sum_3x3_extremes_top_test.sv
module window_sum_3x3_extremes_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsx_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1900;
  localparam int unsigned SETTLE_WAIT  = 8;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam cfg_index_t  UNMAPPED_LO  = 2'd2;
  localparam cfg_index_t  UNMAPPED_HI  = 2'd3;

  typedef enum logic [1:0] {FILL_UNIFORM, FILL_FEW, FILL_RAILS, FILL_FLAT} fill_kind_e;

  typedef struct packed {
    logic [11:0] total;
    logic [4:0]  top_row;
    logic [4:0]  left_col;
  } window_pick_t;

  typedef struct packed {
    window_pick_t largest;
    window_pick_t smallest;
  } matrix_extremes_t;

  class extremes_board;
    logic [5:0] row_reg;
    logic [5:0] col_reg;
    logic [7:0] line_buf [2][32];
    logic [7:0] win [9];
    int unsigned row_at;
    int unsigned col_at;
    window_pick_t top_pick;
    window_pick_t low_pick;
    bit seeded;
    matrix_extremes_t pending_extremes [$];
    int unsigned failures;
    int unsigned matrices_checked;

    function new();
      row_reg = 6'd3;
      col_reg = 6'd3;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 32; j++) line_buf[i][j] = '0;
      for (int k = 0; k < 9; k++) win[k] = '0;
      failures = 0;
      matrices_checked = 0;
      begin_matrix();
    endfunction

    static function int unsigned clamp_dim(logic [5:0] raw);
      if (raw < 6'd3) return 3;
      if (raw > 6'd32) return 32;
      return raw;
    endfunction

    function void begin_matrix();
      row_at = 0;
      col_at = 0;
      seeded = 1'b0;
      top_pick = '0;
      low_pick = '0;
    endfunction

    function void write_register(cfg_index_t idx, logic [5:0] data);
      case (idx)
        REG_ROW_COUNT: begin
          row_reg = data;
          begin_matrix();
        end
        REG_COLUMN_COUNT: begin
          col_reg = data;
          begin_matrix();
        end
        default: ;
      endcase
    endfunction

    // one raster element in, closing the matrix queues its extremes
    function void note_element(logic [7:0] v);
      int unsigned rows;
      int unsigned cols;
      int unsigned ci;
      int unsigned sum;
      window_pick_t cand;
      matrix_extremes_t done;
      rows = clamp_dim(row_reg);
      cols = clamp_dim(col_reg);
      ci = col_at % 32;
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = line_buf[1][ci];
      win[5] = line_buf[0][ci];
      win[8] = v;
      line_buf[1][ci] = line_buf[0][ci];
      line_buf[0][ci] = v;
      if (row_at >= 2 && col_at >= 2) begin
        sum = 0;
        for (int k = 0; k < 9; k++) sum += win[k];
        cand.total    = sum[11:0];
        cand.top_row  = 5'(row_at - 2);
        cand.left_col = 5'(col_at - 2);
        if (!seeded) begin
          top_pick = cand;
          low_pick = cand;
          seeded = 1'b1;
        end else begin
          if (cand.total > top_pick.total ||
              (cand.total == top_pick.total && cand.left_col < top_pick.left_col))
            top_pick = cand;
          if (cand.total < low_pick.total ||
              (cand.total == low_pick.total && cand.left_col < low_pick.left_col))
            low_pick = cand;
        end
      end
      if (col_at + 1 >= cols) begin
        col_at = 0;
        if (row_at + 1 >= rows) begin
          done.largest  = top_pick;
          done.smallest = low_pick;
          pending_extremes.push_back(done);
          begin_matrix();
        end else begin
          row_at++;
        end
      end else begin
        col_at++;
      end
    endfunction

    function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(matrix_extremes_t got);
      matrix_extremes_t want;
      if (pending_extremes.size() == 0) begin
        $error("result with no matrix outstanding");
        failures++;
        return;
      end
      want = pending_extremes.pop_front();
      matrices_checked++;
      check_field("largest_sum", want.largest.total, got.largest.total);
      check_field("largest_top_row", want.largest.top_row, got.largest.top_row);
      check_field("largest_left_col", want.largest.left_col, got.largest.left_col);
      check_field("smallest_sum", want.smallest.total, got.smallest.total);
      check_field("smallest_top_row", want.smallest.top_row, got.smallest.top_row);
      check_field("smallest_left_col", want.smallest.left_col, got.smallest.left_col);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [5:0]  cfg_data;
  logic        item_valid;
  logic        item_ready;
  logic [7:0]  element_value;
  logic        result_valid;
  logic        result_ready;
  logic [11:0] largest_sum;
  logic [4:0]  largest_top_row;
  logic [4:0]  largest_left_col;
  logic [11:0] smallest_sum;
  logic [4:0]  smallest_top_row;
  logic [4:0]  smallest_left_col;

  extremes_board    board;
  matrix_extremes_t seen_extremes;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      hold_requests;
  int unsigned      holds_done;
  int unsigned      elements_sent;
  int unsigned      writes_done;
  int unsigned      cycle_count;
  int unsigned      rows_eff;
  int unsigned      cols_eff;

  window_sum_3x3_extremes_top dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .element_value     (element_value),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .largest_sum       (largest_sum),
    .largest_top_row   (largest_top_row),
    .largest_left_col  (largest_left_col),
    .smallest_sum      (smallest_sum),
    .smallest_top_row  (smallest_top_row),
    .smallest_left_col (smallest_left_col)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
      if (result_valid && result_ready) begin
        seen_extremes.largest.total     = largest_sum;
        seen_extremes.largest.top_row   = largest_top_row;
        seen_extremes.largest.left_col  = largest_left_col;
        seen_extremes.smallest.total    = smallest_sum;
        seen_extremes.smallest.top_row  = smallest_top_row;
        seen_extremes.smallest.left_col = smallest_left_col;
        board.check_result(seen_extremes);
      end
      if (item_valid && item_ready) board.note_element(element_value);
    end
  end

  // result side, with the long hold counted here
  initial begin
    result_ready <= 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        result_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] pick_value(fill_kind_e fill, logic [7:0] level);
    case (fill)
      FILL_UNIFORM: return 8'($urandom_range(255));
      FILL_FEW:     return 8'($urandom_range(2));
      FILL_RAILS:   return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      default:      return level;
    endcase
  endfunction

  task automatic offer_element(input logic [7:0] v);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (!item_ready);
    elements_sent++;
  endtask

  task automatic send_matrix(input int unsigned count, input fill_kind_e fill,
                             input logic [7:0] level);
    for (int unsigned n = 0; n < count; n++) offer_element(pick_value(fill, level));
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [5:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    writes_done++;
  endtask

  task automatic set_dims(input logic [5:0] rows_raw, input logic [5:0] cols_raw);
    write_reg(REG_ROW_COUNT, rows_raw, 1'b1);
    write_reg(REG_COLUMN_COUNT, cols_raw, 1'b0);
    rows_eff = extremes_board::clamp_dim(rows_raw);
    cols_eff = extremes_board::clamp_dim(cols_raw);
  endtask

  // input quiet, all results in, block given time to go idle
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_extremes.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    logic [5:0]  rows_raw;
    logic [5:0]  cols_raw;
    int unsigned area;
    board = new();
    cycle_count = 0;
    elements_sent = 0;
    writes_done = 0;
    hold_requests = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rows_eff = 3;
    cols_eff = 3;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_ROW_COUNT;
    cfg_data      <= '0;
    item_valid    <= 1'b0;
    element_value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-scale matrix at the reset size, every window ties
    send_matrix(9, FILL_FLAT, 8'hFF);
    // writes to unmapped indexes must not disturb a matrix in progress
    send_matrix(4, FILL_UNIFORM, 8'h00);
    settle();
    write_reg(UNMAPPED_LO, 6'h3F, 1'b0);
    send_matrix(2, FILL_RAILS, 8'h00);
    settle();
    write_reg(UNMAPPED_HI, 6'h2A, 1'b0);
    send_matrix(3, FILL_RAILS, 8'h00);
    // a real write drops the partial matrix
    send_matrix(3, FILL_UNIFORM, 8'h00);
    settle();
    set_dims(6'd0, 6'd1);

    // output held off while the input keeps coming
    hold_requests++;
    for (int m = 0; m < 8; m++) send_matrix(9, FILL_UNIFORM, 8'h00);

    phase = 0;
    while (elements_sent < ITEM_TARGET + 21) begin
      settle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (phase == 0) begin
        rows_raw = 6'h3F;
        cols_raw = 6'h00;
      end else if (phase == 1) begin
        rows_raw = 6'd2;
        cols_raw = 6'd32;
      end else begin
        case ($urandom_range(9))
          0: begin
            rows_raw = 6'($urandom_range(2));
            cols_raw = 6'($urandom_range(3, 8));
          end
          1: begin
            rows_raw = 6'($urandom_range(33, 63));
            cols_raw = 6'($urandom_range(3, 4));
          end
          2: begin
            rows_raw = 6'($urandom_range(3, 4));
            cols_raw = 6'($urandom_range(32, 63));
          end
          default: begin
            rows_raw = 6'($urandom_range(3, 7));
            cols_raw = 6'($urandom_range(3, 7));
          end
        endcase
      end
      if ($urandom_range(4) == 0)
        write_reg(($urandom_range(1) != 0) ? UNMAPPED_HI : UNMAPPED_LO, 6'($urandom), 1'b1);
      set_dims(rows_raw, cols_raw);
      area = rows_eff * cols_eff;
      for (int m = $urandom_range(1, 4); m > 0; m--)
        send_matrix(area, fill_kind_e'($urandom_range(3)), 8'($urandom));
      if ($urandom_range(3) == 0)
        send_matrix($urandom_range(1, area - 1), FILL_UNIFORM, 8'h00);
      phase++;
    end

    settle();
    $display("%0d elements, %0d register writes, %0d matrix results checked",
             elements_sent, writes_done, board.matrices_checked);
    $display("sizes 3x3 to 32-row and 32-column matrices, four idling mixes, one long hold");
    if (board.failures == 0 && board.pending_extremes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
